>>> src/ssd_pkg.sv
// Shared types, constants and register codes of the speech segment detector.
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int WINDOW_LEN_DEF    = 512;
  localparam int POSITION_BITS_DEF = 32;
  localparam int SILENCE_BITS      = 17;
  localparam int CMDQ_DEPTH        = 2;
  localparam int OUTQ_DEPTH        = 4;
  localparam int CFG_IDX_BITS      = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPEECH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SPEECH_LEN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_SILENCE_LEN  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_LEN          = 2'd3;

  localparam logic [15:0] SPEECH_THRESHOLD_RST = 16'd16384;
  localparam logic [15:0] MIN_SPEECH_LEN_RST   = 16'd4000;
  localparam logic [15:0] MIN_SILENCE_LEN_RST  = 16'd4800;
  localparam logic [15:0] PAD_LEN_RST          = 16'd2400;

  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_END    = 1'b1;

  typedef struct packed {
    logic [15:0] speech_threshold;
    logic [15:0] min_speech_len;
    logic [15:0] min_silence_len;
    logic [15:0] pad_len;
  } ssd_cfg_t;

  typedef struct packed {
    logic offer;
    logic last;
  } ssd_cmd_flags_t;

  typedef struct packed {
    logic [31:0] segment_start;
    logic [31:0] segment_end;
    logic        has_segment;
    logic        stream_done;
  } ssd_result_t;

endpackage

>>> src/ssd_queue.sv
// Small register queue with up to two writes and one read per cycle.
`timescale 1ns / 1ps
module ssd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en0,
  input  logic [WIDTH-1:0]           wr_data0,
  input  logic                       wr_en1,
  input  logic [WIDTH-1:0]           wr_data1,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH):0]     count
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic [AW-1:0]    tail_plus1;

  assign tail_plus1 = tail_r + AW'(1);
  assign head_nxt   = head_r + AW'(rd_en);
  assign tail_nxt   = tail_r + AW'(wr_en0) + AW'(wr_en1);
  assign count_nxt  = count_r + (AW+1)'(wr_en0) + (AW+1)'(wr_en1) - (AW+1)'(rd_en);
  assign rd_data    = mem_r[head_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem_r[tail_r] <= wr_data0;
    end
    if (wr_en1) begin
      mem_r[tail_plus1] <= wr_data1;
    end
  end

endmodule

>>> src/ssd_front.sv
// Front end: window classification, speech tracking and segment close commands.
`timescale 1ns / 1ps
module ssd_front #(
  parameter int WINDOW_LEN    = ssd_pkg::WINDOW_LEN_DEF,
  parameter int POSITION_BITS = ssd_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssd_pkg::ssd_cfg_t            cfg,
  input  logic                         accept,
  input  logic                         operation,
  input  logic [15:0]                  speech_prob,
  input  logic [31:0]                  total_samples,
  output logic                         cmd_push,
  output ssd_pkg::ssd_cmd_flags_t      cmd_flags,
  output logic [POSITION_BITS-1:0]     cmd_start,
  output logic [POSITION_BITS-1:0]     cmd_stop
);
  import ssd_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int SW = (PB > SILENCE_BITS) ? PB : SILENCE_BITS;
  localparam int NW = (PB > 32) ? PB : 32;
  localparam logic [PB-1:0] PMAX = '1;

  logic [PB-1:0]           pos_r, pos_nxt;
  logic                    in_speech_r, in_speech_nxt;
  logic [PB-1:0]           open_start_r, open_start_nxt;
  logic [SILENCE_BITS-1:0] silence_r, silence_nxt;

  logic [PB:0]             pos_sum;
  logic [PB-1:0]           pos_inc;
  logic [SILENCE_BITS-1:0] sil_inc;
  logic                    speech_win;
  logic                    close_seg;
  logic [SW-1:0]           close_a;
  logic [SW-1:0]           close_b;
  logic [PB-1:0]           close_stop;
  logic [PB-1:0]           len_clip;

  assign pos_sum    = {1'b0, pos_r} + (PB+1)'(WINDOW_LEN);
  assign pos_inc    = pos_sum[PB] ? PMAX : pos_sum[PB-1:0];
  assign sil_inc    = silence_r + SILENCE_BITS'(WINDOW_LEN);
  assign speech_win = speech_prob >= cfg.speech_threshold;
  assign close_seg  = in_speech_r && !speech_win &&
                      (sil_inc >= SILENCE_BITS'(cfg.min_silence_len));
  assign close_a    = SW'(pos_inc);
  assign close_b    = SW'(sil_inc);
  assign close_stop = (close_a > close_b) ? PB'(close_a - close_b) : '0;
  assign len_clip   = (NW'(total_samples) > NW'(PMAX)) ? PMAX : PB'(total_samples);

  always_comb begin
    pos_nxt         = pos_r;
    in_speech_nxt   = in_speech_r;
    open_start_nxt  = open_start_r;
    silence_nxt     = silence_r;
    cmd_push        = 1'b0;
    cmd_flags.offer = 1'b0;
    cmd_flags.last  = 1'b0;
    cmd_start       = open_start_r;
    cmd_stop        = close_stop;
    if (accept) begin
      if (operation == OP_END) begin
        cmd_push        = 1'b1;
        cmd_flags.offer = in_speech_r;
        cmd_flags.last  = 1'b1;
        cmd_stop        = len_clip;
        pos_nxt         = '0;
        in_speech_nxt   = 1'b0;
        open_start_nxt  = '0;
        silence_nxt     = '0;
      end else begin
        pos_nxt = pos_inc;
        if (speech_win) begin
          if (!in_speech_r) begin
            in_speech_nxt  = 1'b1;
            open_start_nxt = pos_r;
          end
          silence_nxt = '0;
        end else if (in_speech_r) begin
          if (close_seg) begin
            cmd_push        = 1'b1;
            cmd_flags.offer = 1'b1;
            in_speech_nxt   = 1'b0;
            silence_nxt     = '0;
          end else begin
            silence_nxt = sil_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      in_speech_r  <= 1'b0;
      open_start_r <= '0;
      silence_r    <= '0;
    end else begin
      pos_r        <= pos_nxt;
      in_speech_r  <= in_speech_nxt;
      open_start_r <= open_start_nxt;
      silence_r    <= silence_nxt;
    end
  end

endmodule

>>> src/ssd_back.sv
// Back end: length check, padding, merging with the held segment and flushing.
`timescale 1ns / 1ps
module ssd_back #(
  parameter int POSITION_BITS = ssd_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssd_pkg::ssd_cfg_t            cfg,
  input  logic                         cmd_valid,
  input  ssd_pkg::ssd_cmd_flags_t      cmd_flags,
  input  logic [POSITION_BITS-1:0]     cmd_start,
  input  logic [POSITION_BITS-1:0]     cmd_stop,
  output logic                         cmd_pop,
  input  logic                         res_room,
  output logic                         res_wr0,
  output logic                         res_wr1,
  output ssd_pkg::ssd_result_t         res_data0,
  output ssd_pkg::ssd_result_t         res_data1
);
  import ssd_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] PMAX = '1;

  logic          held_valid_r, held_valid_nxt;
  logic [PB-1:0] held_start_r, held_start_nxt;
  logic [PB-1:0] held_end_r, held_end_nxt;

  logic          fire;
  logic          keep;
  logic [PB-1:0] pad_w;
  logic [PB:0]   pad_sum;
  logic [PB-1:0] pad_start;
  logic [PB-1:0] pad_stop;
  logic          merge;
  logic          emit_old;
  logic          hv_o;
  logic [PB-1:0] hs_o;
  logic [PB-1:0] he_o;
  logic [PB-1:0] clip_stop;
  logic [PB-1:0] clip_start;
  ssd_result_t   old_res;
  ssd_result_t   flush_res;

  assign fire    = cmd_valid && res_room;
  assign cmd_pop = fire;

  assign pad_w     = PB'(cfg.pad_len);
  assign keep      = cmd_flags.offer && (cmd_stop > cmd_start) &&
                     ((cmd_stop - cmd_start) >= PB'(cfg.min_speech_len));
  assign pad_sum   = {1'b0, cmd_stop} + (PB+1)'(cfg.pad_len);
  assign pad_stop  = pad_sum[PB] ? PMAX : pad_sum[PB-1:0];
  assign pad_start = (cmd_start > pad_w) ? (cmd_start - pad_w) : '0;
  assign merge     = held_valid_r && (pad_start <= held_end_r);

  always_comb begin
    hv_o     = held_valid_r;
    hs_o     = held_start_r;
    he_o     = held_end_r;
    emit_old = 1'b0;
    if (keep) begin
      if (merge) begin
        he_o = (pad_stop > held_end_r) ? pad_stop : held_end_r;
      end else begin
        emit_old = held_valid_r;
        hv_o     = 1'b1;
        hs_o     = pad_start;
        he_o     = pad_stop;
      end
    end
  end

  assign clip_stop  = (he_o < cmd_stop) ? he_o : cmd_stop;
  assign clip_start = (hs_o < clip_stop) ? hs_o : clip_stop;

  always_comb begin
    old_res.segment_start = 32'(held_start_r);
    old_res.segment_end   = 32'(held_end_r);
    old_res.has_segment   = 1'b1;
    old_res.stream_done   = 1'b0;
    flush_res.stream_done = 1'b1;
    if (hv_o) begin
      flush_res.segment_start = 32'(clip_start);
      flush_res.segment_end   = 32'(clip_stop);
      flush_res.has_segment   = 1'b1;
    end else begin
      flush_res.segment_start = '0;
      flush_res.segment_end   = '0;
      flush_res.has_segment   = 1'b0;
    end
  end

  always_comb begin
    res_wr0        = fire && (emit_old || cmd_flags.last);
    res_wr1        = fire && emit_old && cmd_flags.last;
    res_data0      = emit_old ? old_res : flush_res;
    res_data1      = flush_res;
    held_valid_nxt = held_valid_r;
    held_start_nxt = held_start_r;
    held_end_nxt   = held_end_r;
    if (fire) begin
      if (cmd_flags.last) begin
        held_valid_nxt = 1'b0;
        held_start_nxt = '0;
        held_end_nxt   = '0;
      end else begin
        held_valid_nxt = hv_o;
        held_start_nxt = hs_o;
        held_end_nxt   = he_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_start_r <= '0;
      held_end_r   <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_start_r <= held_start_nxt;
      held_end_r   <= held_end_nxt;
    end
  end

endmodule

>>> src/speech_segment_detector_unit.sv
// Top level of the speech segment detector: configuration registers, queues and both ends.
//
// The input channel takes one request per window (operation 0, with its speech
// probability) or an end-of-stream request (operation 1, with total_samples).
// A request is taken when in_push is high and in_full is low. Results come out
// of a queue: while out_empty is low the oldest segment is on the out_ ports and
// out_pop takes it. An end request always yields a result with stream_done set.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// One request is taken every cycle while in_full is low. The front end tracks
// speech and silence and writes any command it makes into the command queue at
// the edge that takes its request; the back end, which pads, merges and flushes
// segments, pops commands from that queue and writes its results to the result queue.
// A two-entry command queue separates the two ends, and a four-entry result
// queue holds results while the receiver stalls; once it holds more than two
// results the back end stops, the command queue fills and in_full rises.
// Synchronous reset clears both queues, the detection state and loads the
// default register values.
`timescale 1ns / 1ps
module speech_segment_detector_unit #(
  parameter int WINDOW_LEN    = ssd_pkg::WINDOW_LEN_DEF,
  parameter int POSITION_BITS = ssd_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_operation,
  input  logic [15:0]                       in_speech_prob,
  input  logic [31:0]                       in_total_samples,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [31:0]                       out_segment_start,
  output logic [31:0]                       out_segment_end,
  output logic                              out_has_segment,
  output logic                              out_stream_done,
  input  logic                              cfg_wr_en,
  input  logic [ssd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [15:0]                       cfg_wdata
);
  import ssd_pkg::*;

  localparam int PB  = POSITION_BITS;
  localparam int CQW = $bits(ssd_cmd_flags_t) + 2 * PB;
  localparam int RQW = $bits(ssd_result_t);
  localparam int CAW = $clog2(CMDQ_DEPTH);
  localparam int RAW = $clog2(OUTQ_DEPTH);

  ssd_cfg_t cfg_r, cfg_nxt;

  logic                 accept;
  logic                 fc_push;
  ssd_cmd_flags_t       fc_flags;
  logic [PB-1:0]        fc_start;
  logic [PB-1:0]        fc_stop;

  logic [CQW-1:0]       cq_rd_data;
  logic [CAW:0]         cq_count;
  ssd_cmd_flags_t       cq_flags;
  logic [PB-1:0]        cq_start;
  logic [PB-1:0]        cq_stop;
  logic                 cq_pop;

  logic [RAW:0]         rq_count;
  logic                 rq_room;
  logic                 rq_pop;
  logic                 rs_wr0;
  logic                 rs_wr1;
  ssd_result_t          rs_data0;
  ssd_result_t          rs_data1;
  ssd_result_t          rq_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPEECH_THRESHOLD: cfg_nxt.speech_threshold = cfg_wdata;
        REG_MIN_SPEECH_LEN:   cfg_nxt.min_speech_len   = cfg_wdata;
        REG_MIN_SILENCE_LEN:  cfg_nxt.min_silence_len  = cfg_wdata;
        REG_PAD_LEN:          cfg_nxt.pad_len          = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_threshold <= SPEECH_THRESHOLD_RST;
      cfg_r.min_speech_len   <= MIN_SPEECH_LEN_RST;
      cfg_r.min_silence_len  <= MIN_SILENCE_LEN_RST;
      cfg_r.pad_len          <= PAD_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = (cq_count == (CAW+1)'(CMDQ_DEPTH));
  assign accept  = in_push && !in_full;

  ssd_front #(
    .WINDOW_LEN    (WINDOW_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .operation     (in_operation),
    .speech_prob   (in_speech_prob),
    .total_samples (in_total_samples),
    .cmd_push      (fc_push),
    .cmd_flags     (fc_flags),
    .cmd_start     (fc_start),
    .cmd_stop      (fc_stop)
  );

  ssd_queue #(
    .WIDTH (CQW),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en0   (fc_push),
    .wr_data0 ({fc_flags, fc_start, fc_stop}),
    .wr_en1   (1'b0),
    .wr_data1 ('0),
    .rd_en    (cq_pop),
    .rd_data  (cq_rd_data),
    .count    (cq_count)
  );

  assign {cq_flags, cq_start, cq_stop} = cq_rd_data;
  assign rq_room = (rq_count <= (RAW+1)'(OUTQ_DEPTH - 2));

  ssd_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cq_count != '0),
    .cmd_flags (cq_flags),
    .cmd_start (cq_start),
    .cmd_stop  (cq_stop),
    .cmd_pop   (cq_pop),
    .res_room  (rq_room),
    .res_wr0   (rs_wr0),
    .res_wr1   (rs_wr1),
    .res_data0 (rs_data0),
    .res_data1 (rs_data1)
  );

  ssd_queue #(
    .WIDTH (RQW),
    .DEPTH (OUTQ_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en0   (rs_wr0),
    .wr_data0 (rs_data0),
    .wr_en1   (rs_wr1),
    .wr_data1 (rs_data1),
    .rd_en    (rq_pop),
    .rd_data  (rq_rd_data),
    .count    (rq_count)
  );

  assign out_empty         = (rq_count == '0);
  assign rq_pop            = out_pop && !out_empty;
  assign out_segment_start = rq_rd_data.segment_start;
  assign out_segment_end   = rq_rd_data.segment_end;
  assign out_has_segment   = rq_rd_data.has_segment;
  assign out_stream_done   = rq_rd_data.stream_done;

endmodule
